@@ hw/rtl/pixel_word_timestamp_decoder_core_defines.svh @@
// assertion macros for the pixel word timestamp decoder
// used by the top level only, no other dependencies
`ifndef PIXEL_WORD_TIMESTAMP_DECODER_CORE_DEFINES_SVH
`define PIXEL_WORD_TIMESTAMP_DECODER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle, held off during reset
`define PWTD_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition implies consequence in the next cycle, held off during reset
`define PWTD_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ hw/rtl/pwtd_pkg.sv @@
// shared types and constants for the pixel word timestamp decoder
// no dependencies
`default_nettype none

package pwtd_pkg;

    localparam int PWTD_COUNT_WIDTH = 48;
    localparam int WORD_WIDTH       = 64;
    localparam int TOTAL_WIDTH      = 48;
    localparam int ID_WIDTH         = 24;
    localparam int TIME_WIDTH       = 52;
    localparam int ENERGY_WIDTH     = 14;

    // top six bits of a coarse-time control word
    localparam logic [5:0] COARSE_SYNC = 6'h20;

    typedef enum logic [1:0] {
        KIND_CONTROL = 2'd0,
        KIND_COARSE  = 2'd1,
        KIND_EVENT   = 2'd2
    } word_kind_t;

    typedef enum logic [1:0] {
        MATCH_NOW    = 2'd0,
        MATCH_BEFORE = 2'd1,
        MATCH_NONE   = 2'd2
    } match_code_t;

    typedef struct packed {
        word_kind_t              word_kind;
        logic [ID_WIDTH-1:0]     event_id;
        logic [TIME_WIDTH-1:0]   full_time;
        logic [ENERGY_WIDTH-1:0] energy_value;
        match_code_t             match_result;
        logic [TOTAL_WIDTH-1:0]  control_total;
        logic [TOTAL_WIDTH-1:0]  coarse_total;
        logic [TOTAL_WIDTH-1:0]  event_total;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/pwtd_in_stage.sv @@
// input register for detector words
// depends on pwtd_pkg
`default_nettype none

module pwtd_in_stage
    import pwtd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WORD_WIDTH-1:0] s_tdata,
    input  wire logic                  take,
    output logic                       word_valid,
    output logic [WORD_WIDTH-1:0]      word
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [WORD_WIDTH-1:0] word_reg;

    // room when empty or when the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // payload captured on each accepted beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pwtd_decode.sv @@
// word decode, coarse-time tracking and word counters
// depends on pwtd_pkg
`default_nettype none

module pwtd_decode
    import pwtd_pkg::*;
#(
    parameter int COUNT_WIDTH = PWTD_COUNT_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [WORD_WIDTH-1:0] word,
    input  wire logic                  advance,
    output result_t                    result
);

    logic [TIME_WIDTH-1:0]  coarse_now_reg;
    logic [TIME_WIDTH-1:0]  coarse_now_next;
    logic [TIME_WIDTH-1:0]  coarse_before_reg;
    logic [TIME_WIDTH-1:0]  coarse_before_next;
    logic [1:0]             tag_now_reg;
    logic [1:0]             tag_now_next;
    logic [1:0]             tag_before_reg;
    logic [1:0]             tag_before_next;
    logic [COUNT_WIDTH-1:0] control_count_reg;
    logic [COUNT_WIDTH-1:0] control_count_next;
    logic [COUNT_WIDTH-1:0] coarse_count_reg;
    logic [COUNT_WIDTH-1:0] coarse_count_next;
    logic [COUNT_WIDTH-1:0] event_count_reg;
    logic [COUNT_WIDTH-1:0] event_count_next;

    logic                  is_control;
    logic                  is_coarse;
    logic [TIME_WIDTH-1:0] coarse_word;
    logic [ID_WIDTH-1:0]   fine_time;
    logic [2:0]            fine_tag;
    logic                  hit_now;
    logic                  hit_before;

    // field extraction
    assign is_control  = word[63];
    assign is_coarse   = is_control && (word[63:58] == COARSE_SYNC);
    assign coarse_word = {word[51:3], 3'b000};
    assign fine_time   = word[37:14];
    assign fine_tag    = {1'b0, fine_time[23:22]};

    // tag match: equal or one ahead, no wrap past three
    assign hit_now    = (fine_tag == {1'b0, tag_now_reg})
                     || (fine_tag == ({1'b0, tag_now_reg} + 3'd1));
    assign hit_before = (fine_tag == {1'b0, tag_before_reg})
                     || (fine_tag == ({1'b0, tag_before_reg} + 3'd1));

    // next state and result for the word in the input register
    always_comb
    begin
        coarse_now_next    = coarse_now_reg;
        coarse_before_next = coarse_before_reg;
        tag_now_next       = tag_now_reg;
        tag_before_next    = tag_before_reg;
        control_count_next = control_count_reg;
        coarse_count_next  = coarse_count_reg;
        event_count_next   = event_count_reg;

        result.word_kind    = KIND_CONTROL;
        result.event_id     = '0;
        result.full_time    = '0;
        result.energy_value = '0;
        result.match_result = MATCH_NOW;

        if (is_control)
        begin
            control_count_next = control_count_reg + COUNT_WIDTH'(1);
            if (is_coarse)
            begin
                result.word_kind  = KIND_COARSE;
                coarse_count_next = coarse_count_reg + COUNT_WIDTH'(1);
                if (coarse_word != coarse_now_reg)
                begin
                    coarse_before_next = coarse_now_reg;
                    tag_before_next    = tag_now_reg;
                    coarse_now_next    = coarse_word;
                    tag_now_next       = coarse_word[23:22];
                end
            end
        end
        else
        begin
            result.word_kind    = KIND_EVENT;
            event_count_next    = event_count_reg + COUNT_WIDTH'(1);
            result.event_id     = word[62:39];
            result.energy_value = word[13:0];
            // coarse bits 51..24 sit above the 24-bit fine time, no carry
            if (hit_now)
            begin
                result.full_time    = {coarse_now_reg[51:24], fine_time};
                result.match_result = MATCH_NOW;
            end
            else if (hit_before)
            begin
                result.full_time    = {coarse_before_reg[51:24], fine_time};
                result.match_result = MATCH_BEFORE;
            end
            else
            begin
                result.full_time    = '0;
                result.match_result = MATCH_NONE;
            end
        end

        result.control_total = TOTAL_WIDTH'(control_count_next);
        result.coarse_total  = TOTAL_WIDTH'(coarse_count_next);
        result.event_total   = TOTAL_WIDTH'(event_count_next);
    end

    // state moves only when the word is handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarse_now_reg    <= '0;
            coarse_before_reg <= '0;
            tag_now_reg       <= '0;
            tag_before_reg    <= '0;
            control_count_reg <= '0;
            coarse_count_reg  <= '0;
            event_count_reg   <= '0;
        end
        else if (advance)
        begin
            coarse_now_reg    <= coarse_now_next;
            coarse_before_reg <= coarse_before_next;
            tag_now_reg       <= tag_now_next;
            tag_before_reg    <= tag_before_next;
            control_count_reg <= control_count_next;
            coarse_count_reg  <= coarse_count_next;
            event_count_reg   <= event_count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pwtd_out_stage.sv @@
// result register and output beat packing
// depends on pwtd_pkg
`default_nettype none

module pwtd_out_stage
    import pwtd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  result,
    output logic          free,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [239:0]  m_tdata,
    output logic [1:0]    m_tuser
);

    logic    valid_reg;
    result_t result_reg;

    // free when empty or when the held beat is taken this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // pack fields from the lowest bit up
    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.word_kind;
    assign m_tdata  = {4'b0000,
                       result_reg.event_total,
                       result_reg.coarse_total,
                       result_reg.control_total,
                       result_reg.match_result,
                       result_reg.energy_value,
                       result_reg.full_time,
                       result_reg.event_id};

endmodule

`default_nettype wire

@@ hw/rtl/pixel_word_timestamp_decoder_core.sv @@
// Pixel detector word decoder with coarse-time extension of event timestamps.
//
// Input stream (s_*): one 64-bit raw detector word per beat in s_tdata.
// Output stream (m_*): one result beat per input beat, in order.
//   m_tuser holds the word kind: control, coarse-time or event.
//   m_tdata holds event id, extended time, energy, match code and the
//   three running word totals, each total including the current word.
// Path: an accepted beat sits in the input register; m_tvalid rises when the
// result register takes the decoded word, and the beat leaves from there.
// Throughput: one word per cycle while m_tready stays high; decode is field
// selection, two tag compares and three counter increments between the two
// registers.
// Reset: rst_n clears both stages, the coarse times, tags and counters.
// Stall: while m_tready is low the result beat holds; one more word waits
// in the input register, after which s_tready drops until the output drains.
// COUNT_WIDTH sets the counter width; totals carry its low 48 bits.
// Depends on pwtd_pkg, pwtd_in_stage, pwtd_decode, pwtd_out_stage and the defines header.
`default_nettype none
`include "pixel_word_timestamp_decoder_core_defines.svh"

module pixel_word_timestamp_decoder_core
    import pwtd_pkg::*;
#(
    parameter int COUNT_WIDTH = PWTD_COUNT_WIDTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // data_word [63:0]
    input  wire logic [63:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // event_id [23:0], full_time [75:24], energy_value [89:76],
    // match_result [91:90], control_total [139:92], coarse_total [187:140],
    // event_total [235:188], zero fill [239:236]
    output logic [239:0]       m_tdata,
    // word_kind [1:0]
    output logic [1:0]         m_tuser
);

    logic                  word_valid;
    logic [WORD_WIDTH-1:0] word;
    logic                  out_free;
    logic                  advance;
    result_t               result;

    // a word moves on when the result register can take it
    assign advance = word_valid && out_free;

    pwtd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    pwtd_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .word    (word),
        .advance (advance),
        .result  (result)
    );

    pwtd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // checks on decode and flow control
    `PWTD_ASSERT_SAME(a_full_stall_blocks_input, clk, rst_n,
        word_valid && m_tvalid && !m_tready, !s_tready,
        "input accepted while both stages are full and output stalled")
    `PWTD_ASSERT_SAME(a_control_fields_zero, clk, rst_n,
        m_tvalid && (m_tuser != KIND_EVENT), m_tdata[91:0] == 92'd0,
        "control result carries event fields")
    `PWTD_ASSERT_SAME(a_no_match_zero_time, clk, rst_n,
        m_tvalid && (m_tdata[91:90] == MATCH_NONE), m_tdata[75:24] == 52'd0,
        "unmatched event has a nonzero timestamp")
    `PWTD_ASSERT_NEXT(a_advance_gives_result, clk, rst_n,
        advance, m_tvalid,
        "decoded word did not reach the result register")

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for pixel_word_timestamp_decoder_core
// directed table then random words, checked against hand-written results or an in-bench decoder
// depends on pwtd_pkg and the core rtl only

module tb_top;
    import pwtd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 950;

    typedef struct {
        logic [63:0] word;
        bit          fixed;
        result_t     want;
    } dir_row_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;
    logic [1:0]   m_tuser;

    // decoder state mirrored in the bench
    logic [TIME_WIDTH-1:0]       cur_coarse;
    logic [TIME_WIDTH-1:0]       prev_coarse;
    logic [1:0]                  cur_tag;
    logic [1:0]                  prev_tag;
    logic [PWTD_COUNT_WIDTH-1:0] ctl_cnt;
    logic [PWTD_COUNT_WIDTH-1:0] crs_cnt;
    logic [PWTD_COUNT_WIDTH-1:0] evt_cnt;

    result_t  decoded_q[$];
    dir_row_t dir_rows[$];
    bit       steady = 1'b0;
    int       errors = 0;
    int       beats_out = 0;
    int       hits_now = 0;
    int       hits_before = 0;
    int       misses = 0;

    pixel_word_timestamp_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // tag test: equal or one above, no wrap past 3
    function automatic bit tag_accepts(input logic [1:0] stored, input logic [1:0] fine_tag);
        return (stored == fine_tag) || (({1'b0, stored} + 3'd1) == {1'b0, fine_tag});
    endfunction

    // decode one word and advance the mirrored state
    function automatic result_t decode_word(input logic [63:0] w);
        result_t          r;
        logic [TIME_WIDTH-1:0] c;
        logic [23:0]      fine;
        r = '0;
        r.word_kind    = KIND_CONTROL;
        r.match_result = MATCH_NOW;
        if (w[63])
        begin
            ctl_cnt = ctl_cnt + 1'b1;
            if (w[63:58] == COARSE_SYNC)
            begin
                c = {w[51:3], 3'b000};
                r.word_kind = KIND_COARSE;
                crs_cnt = crs_cnt + 1'b1;
                // a repeated coarse time leaves both slots alone
                if (c != cur_coarse)
                begin
                    prev_coarse = cur_coarse;
                    prev_tag    = cur_tag;
                    cur_coarse  = c;
                    cur_tag     = c[23:22];
                end
            end
        end
        else
        begin
            fine = w[37:14];
            r.word_kind    = KIND_EVENT;
            evt_cnt        = evt_cnt + 1'b1;
            r.event_id     = w[62:39];
            r.energy_value = w[13:0];
            if (tag_accepts(cur_tag, fine[23:22]))
            begin
                r.full_time    = {cur_coarse[51:24], fine};
                r.match_result = MATCH_NOW;
                hits_now++;
            end
            else if (tag_accepts(prev_tag, fine[23:22]))
            begin
                r.full_time    = {prev_coarse[51:24], fine};
                r.match_result = MATCH_BEFORE;
                hits_before++;
            end
            else
            begin
                r.full_time    = '0;
                r.match_result = MATCH_NONE;
                misses++;
            end
        end
        r.control_total = ctl_cnt[TOTAL_WIDTH-1:0];
        r.coarse_total  = crs_cnt[TOTAL_WIDTH-1:0];
        r.event_total   = evt_cnt[TOTAL_WIDTH-1:0];
        return r;
    endfunction

    // result written out by hand for the table
    function automatic result_t fixed_result(input word_kind_t kind, input logic [23:0] id,
                                             input logic [51:0] ts, input logic [13:0] energy,
                                             input match_code_t match, input logic [47:0] ctl,
                                             input logic [47:0] crs, input logic [47:0] evt);
        result_t r;
        r.word_kind     = kind;
        r.event_id      = id;
        r.full_time     = ts;
        r.energy_value  = energy;
        r.match_result  = match;
        r.control_total = ctl;
        r.coarse_total  = crs;
        r.event_total   = evt;
        return r;
    endfunction

    // random word: mostly events, some coarse words (often repeats), some other control
    function automatic logic [63:0] random_word();
        logic [63:0] rnd;
        logic [51:0] c;
        int          pick;
        rnd  = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            case ($urandom_range(3))
                0: c = cur_coarse;
                1: c = prev_coarse;
                default: c = {rnd[51:3], 3'b000};
            endcase
            return {COARSE_SYNC, rnd[57:52], c[51:3], rnd[2:0]};
        end
        else if (pick < 18)
            return {1'b1, rnd[62:0]};
        else
            return {1'b0, rnd[62:0]};
    endfunction

    // one input beat, with random gaps unless in a steady stretch
    task automatic send_word(input logic [63:0] w, input bit fixed, input result_t want);
        result_t pred;
        while (!steady && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        pred = decode_word(w);
        decoded_q.push_back(fixed ? want : pred);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %h got %h", name, want, got);
            errors++;
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_out
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (decoded_q.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("word_kind", want.word_kind, m_tuser);
                check_field("event_id", want.event_id, m_tdata[23:0]);
                check_field("full_time", want.full_time, m_tdata[75:24]);
                check_field("energy_value", want.energy_value, m_tdata[89:76]);
                check_field("match_result", want.match_result, m_tdata[91:90]);
                check_field("control_total", want.control_total, m_tdata[139:92]);
                check_field("coarse_total", want.coarse_total, m_tdata[187:140]);
                check_field("event_total", want.event_total, m_tdata[235:188]);
                check_field("zero_fill", 64'd0, m_tdata[239:236]);
            end
        end
    end

    // run guard
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        result_t none;
        none = '0;
        cur_coarse  = '0;
        prev_coarse = '0;
        cur_tag     = '0;
        prev_tag    = '0;
        ctl_cnt     = '0;
        crs_cnt     = '0;
        evt_cnt     = '0;

        // after reset: zero event, all-ones event, foreign control, zero coarse, max coarse
        dir_rows.push_back('{64'h0000_0000_0000_0000, 1'b1,
            fixed_result(KIND_EVENT, 24'h0, 52'h0, 14'h0, MATCH_NOW, 48'd0, 48'd0, 48'd1)});
        dir_rows.push_back('{64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
            fixed_result(KIND_EVENT, 24'hFF_FFFF, 52'h0, 14'h3FFF, MATCH_NONE,
                         48'd0, 48'd0, 48'd2)});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            fixed_result(KIND_CONTROL, 24'h0, 52'h0, 14'h0, MATCH_NOW, 48'd1, 48'd0, 48'd2)});
        dir_rows.push_back('{64'h8000_0000_0000_0000, 1'b1,
            fixed_result(KIND_COARSE, 24'h0, 52'h0, 14'h0, MATCH_NOW, 48'd2, 48'd1, 48'd2)});
        dir_rows.push_back('{64'h83FF_FFFF_FFFF_FFFF, 1'b1,
            fixed_result(KIND_COARSE, 24'h0, 52'h0, 14'h0, MATCH_NOW, 48'd3, 48'd2, 48'd2)});
        // current tag 3, previous tag 0: each fine tag
        dir_rows.push_back('{64'h1234_5630_0ABC_1234, 1'b0, none});
        dir_rows.push_back('{64'h0000_0000_4000_0001, 1'b0, none});
        dir_rows.push_back('{64'h0000_0010_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'h0000_0020_0000_3FFF, 1'b0, none});
        // new coarse with tag 2, previous slot now tag 3
        dir_rows.push_back('{64'h8000_0000_0080_0000, 1'b0, none});
        dir_rows.push_back('{64'h0000_0020_0000_0001, 1'b0, none});
        dir_rows.push_back('{64'h0000_0030_0000_0002, 1'b0, none});
        dir_rows.push_back('{64'h0000_0000_0000_0003, 1'b0, none});
        dir_rows.push_back('{64'h0000_0010_0000_0004, 1'b0, none});
        // repeated coarse time, with and without low junk bits
        dir_rows.push_back('{64'h8000_0000_0080_0000, 1'b0, none});
        dir_rows.push_back('{64'h83F0_0000_0080_0007, 1'b0, none});
        // control words that are not coarse-time words
        dir_rows.push_back('{64'hC000_0000_0000_0000, 1'b0, none});
        dir_rows.push_back('{64'h8400_0000_0000_0000, 1'b0, none});
        // coarse with tag 1, previous tag 2
        dir_rows.push_back('{64'h81F0_0000_0040_0000, 1'b0, none});
        dir_rows.push_back('{64'h0000_0000_0000_0010, 1'b0, none});
        dir_rows.push_back('{64'h0000_0010_0000_0020, 1'b0, none});
        dir_rows.push_back('{64'h0000_0020_0000_0030, 1'b0, none});
        dir_rows.push_back('{64'h0000_0030_0000_0040, 1'b0, none});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = (i >= 300 && i < 500);
            // hold off the sender until the pipeline has drained
            if (i == 600)
            begin
                s_tvalid <= 1'b0;
                while (decoded_q.size() != 0) @(posedge clk);
                @(negedge clk);
            end
            send_word(random_word(), 1'b0, none);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (decoded_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d result beats: %0d events (%0d current, %0d previous, %0d unmatched)",
                 beats_out, evt_cnt, hits_now, hits_before, misses);
        $display("%0d control words, %0d of them coarse-time words", ctl_cnt, crs_cnt);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
